/* hw/rtl/cbz_pkg.sv */
// cbz_pkg: shared constants and types for the cubic bezier point/tangent unit
// no dependencies; imported by every module of the block
`default_nettype none

package cbz_pkg;

  // blend weights are carried as unsigned Q.30, 1.0 = 2^30
  localparam int WEIGHT_FRAC = 30;
  localparam int WGT_W       = WEIGHT_FRAC + 1;

  // configuration port
  localparam int CFG_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_POINTS = 4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_POINT_ZERO  = 3'd0;
  localparam cfg_idx_t REG_POINT_ONE   = 3'd1;
  localparam cfg_idx_t REG_POINT_TWO   = 3'd2;
  localparam cfg_idx_t REG_POINT_THREE = 3'd3;

  // pipeline depth: weight stages followed by per-axis stages
  localparam int WGT_STAGES = 5;
  localparam int AX_STAGES  = 4;
  localparam int NUM_STAGES = WGT_STAGES + AX_STAGES;

  typedef struct packed {
    logic [WGT_W-1:0] uu;
    logic [WGT_W-1:0] ut;
    logic [WGT_W-1:0] tt;
    logic [WGT_W-1:0] uuu;
    logic [WGT_W-1:0] uut;
    logic [WGT_W-1:0] utt;
    logic [WGT_W-1:0] ttt;
  } weights_t;

endpackage

`default_nettype wire

/* hw/rtl/cbz_weights.sv */
// cbz_weights: five-stage pipeline that turns t into u/t blend products in Q.30
// depends on cbz_pkg (weights_t, WGT_W, WEIGHT_FRAC, WGT_STAGES)
`default_nettype none

module cbz_weights
  import cbz_pkg::*;
#(
  parameter int PARAM_FRAC_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic [WGT_STAGES-1:0]    en,
  input  wire logic [PARAM_FRAC_BITS:0] param,
  output weights_t                      wgt
);

  localparam int F    = PARAM_FRAC_BITS;
  localparam int PW   = F + 1;
  localparam int SQ_W = 2 * F + 2;
  localparam int CB_W = WGT_W + PW;
  localparam int SH   = 2 * F - WEIGHT_FRAC;
  localparam int RSH  = (SH > 0) ? SH : 0;
  localparam int LSH  = (SH < 0) ? -SH : 0;
  localparam int RH_POS = (RSH > 0) ? RSH - 1 : 0;

  localparam logic [PW-1:0]   ONE   = {1'b1, {F{1'b0}}};
  localparam logic [SQ_W-1:0] RHALF = (RSH > 0) ? (SQ_W'(1) << RH_POS) : '0;
  localparam logic [CB_W-1:0] CHALF = CB_W'(1) << (F - 1);

  // stage 1: clamp
  logic [PW-1:0] t1_nxt, u1_nxt;
  logic [PW-1:0] t1_r, u1_r;

  assign t1_nxt = (param > ONE) ? ONE : param;
  assign u1_nxt = ONE - t1_nxt;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t1_r <= t1_nxt;
      u1_r <= u1_nxt;
    end
  end

  // stage 2: square terms, 2F fractional bits
  logic [SQ_W-1:0] uu2_r, ut2_r, tt2_r;
  logic [PW-1:0]   t2_r, u2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      uu2_r <= SQ_W'(u1_r) * SQ_W'(u1_r);
      ut2_r <= SQ_W'(u1_r) * SQ_W'(t1_r);
      tt2_r <= SQ_W'(t1_r) * SQ_W'(t1_r);
      t2_r  <= t1_r;
      u2_r  <= u1_r;
    end
  end

  // stage 3: bring square terms to Q.30, rounding half up
  logic [WGT_W-1:0] uu3_nxt, ut3_nxt, tt3_nxt;
  logic [WGT_W-1:0] uu3_r, ut3_r, tt3_r;
  logic [PW-1:0]    t3_r, u3_r;

  assign uu3_nxt = WGT_W'((uu2_r + RHALF) >> RSH) << LSH;
  assign ut3_nxt = WGT_W'((ut2_r + RHALF) >> RSH) << LSH;
  assign tt3_nxt = WGT_W'((tt2_r + RHALF) >> RSH) << LSH;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      uu3_r <= uu3_nxt;
      ut3_r <= ut3_nxt;
      tt3_r <= tt3_nxt;
      t3_r  <= t2_r;
      u3_r  <= u2_r;
    end
  end

  // stage 4: cube terms, Q.30 + F fractional bits
  logic [CB_W-1:0]  uuu4_r, uut4_r, utt4_r, ttt4_r;
  logic [WGT_W-1:0] uu4_r, ut4_r, tt4_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      uuu4_r <= CB_W'(uu3_r) * CB_W'(u3_r);
      uut4_r <= CB_W'(uu3_r) * CB_W'(t3_r);
      utt4_r <= CB_W'(tt3_r) * CB_W'(u3_r);
      ttt4_r <= CB_W'(tt3_r) * CB_W'(t3_r);
      uu4_r  <= uu3_r;
      ut4_r  <= ut3_r;
      tt4_r  <= tt3_r;
    end
  end

  // stage 5: round cube terms back to Q.30
  weights_t wgt_nxt;
  weights_t wgt_r;

  always_comb begin
    wgt_nxt.uu  = uu4_r;
    wgt_nxt.ut  = ut4_r;
    wgt_nxt.tt  = tt4_r;
    wgt_nxt.uuu = WGT_W'((uuu4_r + CHALF) >> F);
    wgt_nxt.uut = WGT_W'((uut4_r + CHALF) >> F);
    wgt_nxt.utt = WGT_W'((utt4_r + CHALF) >> F);
    wgt_nxt.ttt = WGT_W'((ttt4_r + CHALF) >> F);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      wgt_r <= wgt_nxt;
    end
  end

  assign wgt = wgt_r;

endmodule

`default_nettype wire

/* hw/rtl/cbz_axis.sv */
// cbz_axis: four-stage per-axis pipeline: products, partial sums, rounding, saturation
// depends on cbz_pkg (weights_t, WGT_W, WEIGHT_FRAC, AX_STAGES)
`default_nettype none

module cbz_axis
  import cbz_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic [AX_STAGES-1:0]          en,
  input  wire weights_t                      wgt,
  input  wire logic signed [COORD_WIDTH-1:0] p0,
  input  wire logic signed [COORD_WIDTH-1:0] p1,
  input  wire logic signed [COORD_WIDTH-1:0] p2,
  input  wire logic signed [COORD_WIDTH-1:0] p3,
  output logic signed [COORD_WIDTH-1:0]      pos,
  output logic signed [COORD_WIDTH+2:0]      tan
);

  localparam int W     = COORD_WIDTH;
  localparam int MP_W  = WGT_W + 1 + W;
  localparam int MT_W  = MP_W + 1;
  localparam int PS_W  = W + 35;
  localparam int TS_W  = W + 36;
  localparam int PQ_W  = PS_W - WEIGHT_FRAC;
  localparam int TQ_W  = TS_W - WEIGHT_FRAC;
  localparam int TAN_W = W + 3;

  localparam logic signed [PS_W-1:0] PHALF = PS_W'(1) <<< (WEIGHT_FRAC - 1);
  localparam logic signed [TS_W-1:0] THALF = TS_W'(1) <<< (WEIGHT_FRAC - 1);

  // weights as non-negative signed operands
  logic signed [WGT_W:0] s_uu, s_ut, s_tt, s_uuu, s_uut, s_utt, s_ttt;
  logic signed [W:0]     d10, d21, d32;

  assign s_uu  = signed'({1'b0, wgt.uu});
  assign s_ut  = signed'({1'b0, wgt.ut});
  assign s_tt  = signed'({1'b0, wgt.tt});
  assign s_uuu = signed'({1'b0, wgt.uuu});
  assign s_uut = signed'({1'b0, wgt.uut});
  assign s_utt = signed'({1'b0, wgt.utt});
  assign s_ttt = signed'({1'b0, wgt.ttt});

  assign d10 = (W + 1)'(p1) - (W + 1)'(p0);
  assign d21 = (W + 1)'(p2) - (W + 1)'(p1);
  assign d32 = (W + 1)'(p3) - (W + 1)'(p2);

  // stage 1: products
  logic signed [MP_W-1:0] a_r, b_r, c_r, d_r;
  logic signed [MT_W-1:0] e_r, f_r, g_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_r <= s_uuu * MP_W'(p0);
      b_r <= s_uut * MP_W'(p1);
      c_r <= s_utt * MP_W'(p2);
      d_r <= s_ttt * MP_W'(p3);
      e_r <= s_uu * MT_W'(d10);
      f_r <= s_ut * MT_W'(d21);
      g_r <= s_tt * MT_W'(d32);
    end
  end

  // stage 2: scale by 3 and 6, pairwise sums
  logic signed [PS_W-1:0] pa_r, pb_r;
  logic signed [TS_W-1:0] ta_r, tb_r;
  logic signed [PS_W-1:0] xb, xc;
  logic signed [TS_W-1:0] xe, xf, xg;

  assign xb = PS_W'(b_r);
  assign xc = PS_W'(c_r);
  assign xe = TS_W'(e_r);
  assign xf = TS_W'(f_r);
  assign xg = TS_W'(g_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pa_r <= PS_W'(a_r) + xb + (xb <<< 1);
      pb_r <= xc + (xc <<< 1) + PS_W'(d_r);
      ta_r <= xe + (xe <<< 1) + (xf <<< 1) + (xf <<< 2);
      tb_r <= xg + (xg <<< 1);
    end
  end

  // stage 3: full sum plus rounding bias
  logic signed [PS_W-1:0] ps_r;
  logic signed [TS_W-1:0] ts_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ps_r <= pa_r + pb_r + PHALF;
      ts_r <= ta_r + tb_r + THALF;
    end
  end

  // stage 4: floor shift and saturate
  logic signed [PQ_W-1:0]  pq;
  logic signed [TQ_W-1:0]  tq;
  logic [W-1:0]            pos_nxt;
  logic [TAN_W-1:0]        tan_nxt;
  logic [W-1:0]            pos_r;
  logic [TAN_W-1:0]        tan_r;

  assign pq = PQ_W'(ps_r >>> WEIGHT_FRAC);
  assign tq = TQ_W'(ts_r >>> WEIGHT_FRAC);

  always_comb begin
    // in range when all bits above the result's sign agree with it
    if (&pq[PQ_W-1:W-1] || !(|pq[PQ_W-1:W-1])) begin
      pos_nxt = pq[W-1:0];
    end else if (pq[PQ_W-1]) begin
      pos_nxt = {1'b1, {(W-1){1'b0}}};
    end else begin
      pos_nxt = {1'b0, {(W-1){1'b1}}};
    end
    if (&tq[TQ_W-1:TAN_W-1] || !(|tq[TQ_W-1:TAN_W-1])) begin
      tan_nxt = tq[TAN_W-1:0];
    end else if (tq[TQ_W-1]) begin
      tan_nxt = {1'b1, {(TAN_W-1){1'b0}}};
    end else begin
      tan_nxt = {1'b0, {(TAN_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pos_r <= pos_nxt;
      tan_r <= tan_nxt;
    end
  end

  assign pos = signed'(pos_r);
  assign tan = signed'(tan_r);

endmodule

`default_nettype wire

/* hw/rtl/cubic_bezier_point_tangent_unit.sv */
// throughput: one parameter value per cycle while out_ready holds; every stage holds one item with its own valid
// bit, and a stage empties forward whenever the next one is free or moving
// reset (rst_n low, synchronous): all valid bits and the four control points clear to zero
// cubic_bezier_point_tangent_unit: top level, config registers and pipeline control
// depends on cbz_pkg, cbz_weights, cbz_axis
`default_nettype none

module cubic_bezier_point_tangent_unit
  import cbz_pkg::*;
#(
  parameter int COORD_WIDTH     = 16,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]              cfg_data,
  // parameter input
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [PARAM_FRAC_BITS:0]      in_param,
  // point and tangent output
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0]      out_pos_x,
  output logic signed [COORD_WIDTH-1:0]      out_pos_y,
  output logic signed [COORD_WIDTH-1:0]      out_pos_z,
  output logic signed [COORD_WIDTH+2:0]      out_tan_x,
  output logic signed [COORD_WIDTH+2:0]      out_tan_y,
  output logic signed [COORD_WIDTH+2:0]      out_tan_z
);

  localparam int W      = COORD_WIDTH;
  localparam int PACK_W = (3 * W > CFG_W) ? 3 * W : CFG_W;

  // control point registers
  logic [CFG_W-1:0] pt_r [NUM_POINTS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        pt_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POINT_ZERO:  pt_r[0] <= cfg_data;
        REG_POINT_ONE:   pt_r[1] <= cfg_data;
        REG_POINT_TWO:   pt_r[2] <= cfg_data;
        REG_POINT_THREE: pt_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage load enables
  logic [NUM_STAGES-1:0] vld_r, vld_nxt;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  // weights
  weights_t wgt;

  cbz_weights #(
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_weights (
    .clk   (clk),
    .en    (en[WGT_STAGES-1:0]),
    .param (in_param),
    .wgt   (wgt)
  );

  // per-axis evaluation; coordinates above bit 47 read as zero
  logic [PACK_W-1:0]             pt_ext [NUM_POINTS];
  logic signed [W-1:0]           pos_w  [3];
  logic signed [W+2:0]           tan_w  [3];

  always_comb begin
    for (int i = 0; i < NUM_POINTS; i++) begin
      pt_ext[i] = PACK_W'(pt_r[i]);
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    cbz_axis #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_axis (
      .clk (clk),
      .en  (en[NUM_STAGES-1:WGT_STAGES]),
      .wgt (wgt),
      .p0  (signed'(pt_ext[0][a*W +: W])),
      .p1  (signed'(pt_ext[1][a*W +: W])),
      .p2  (signed'(pt_ext[2][a*W +: W])),
      .p3  (signed'(pt_ext[3][a*W +: W])),
      .pos (pos_w[a]),
      .tan (tan_w[a])
    );
  end

  assign out_pos_x = pos_w[0];
  assign out_pos_y = pos_w[1];
  assign out_pos_z = pos_w[2];
  assign out_tan_x = tan_w[0];
  assign out_tan_y = tan_w[1];
  assign out_tan_z = tan_w[2];

endmodule

`default_nettype wire

/* hw/rtl/cbz_checker.sv */
// cbz_checker: port-level assertions for the bezier unit, bound to the top level
// depends on cbz_pkg (NUM_STAGES) and cubic_bezier_point_tangent_unit
`default_nettype none

module cbz_checker
  import cbz_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [COORD_WIDTH-1:0] out_pos_x,
  input wire logic [COORD_WIDTH+2:0] out_tan_x
);

  localparam int CNT_W = $clog2(NUM_STAGES + 1);

  // beats taken in but not yet delivered
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_beat && !out_beat) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (out_beat && !in_beat) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_tan_x))
    else $error("result beat changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with free output stage");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result beat with no input outstanding");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NUM_STAGES))
    else $error("more items in flight than pipeline stages");

endmodule

bind cubic_bezier_point_tangent_unit cbz_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_cbz_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_pos_x (out_pos_x),
  .out_tan_x (out_tan_x)
);

`default_nettype wire
